### hdl/ngrp_pkg.sv
// Shared types, character codes and the field selection table of the NMEA field parser.
package ngrp_pkg;

  // ASCII characters that steer the parser.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_A      = 8'h41;

  localparam int unsigned CNT_MAX = 15;

  typedef enum logic [1:0] {
    EV_CHAR = 2'd0,
    EV_END  = 2'd1,
    EV_OVF  = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    HK_REJECT = 2'd0,
    HK_GGA    = 2'd1,
    HK_RMC    = 2'd2,
    HK_MATCH  = 2'd3
  } header_e;

  typedef enum logic [2:0] {
    FID_TIME = 3'd0,
    FID_LAT  = 3'd1,
    FID_LON  = 3'd2,
    FID_FIX  = 3'd3,
    FID_ALT  = 3'd4,
    FID_SPD  = 3'd5,
    FID_DATE = 3'd6
  } field_e;

  typedef struct packed {
    logic       hit;
    field_e     fid;
    logic [3:0] limit;
  } field_sel_t;

  // One result word as it leaves the parse logic.
  typedef struct packed {
    event_e     event_kind;
    logic [1:0] sentence_kind;
    logic [2:0] field_id;
    logic [3:0] char_index;
    logic [7:0] char_value;
    logic       batch_complete;
  } result_t;

  // Which field, if any, starts after the given number of commas.
  function automatic field_sel_t select_field(header_e hk, logic [3:0] commas);
    field_sel_t s;
    s = '{hit: 1'b0, fid: FID_TIME, limit: 4'd0};
    if (hk == HK_GGA) begin
      case (commas)
        4'd1: s = '{hit: 1'b1, fid: FID_TIME, limit: 4'd8};
        4'd2: s = '{hit: 1'b1, fid: FID_LAT,  limit: 4'd9};
        4'd4: s = '{hit: 1'b1, fid: FID_LON,  limit: 4'd10};
        4'd6: s = '{hit: 1'b1, fid: FID_FIX,  limit: 4'd1};
        4'd9: s = '{hit: 1'b1, fid: FID_ALT,  limit: 4'd5};
        default: s.hit = 1'b0;
      endcase
    end else if (hk == HK_RMC) begin
      case (commas)
        4'd7: s = '{hit: 1'b1, fid: FID_SPD,  limit: 4'd5};
        4'd9: s = '{hit: 1'b1, fid: FID_DATE, limit: 4'd6};
        default: s.hit = 1'b0;
      endcase
    end
    return s;
  endfunction

  // Sentence kind as reported: only a header recognised as GGA or RMC counts; an open match reports as rejected.
  function automatic logic [1:0] kind_of(header_e hk);
    return (hk == HK_GGA || hk == HK_RMC) ? 2'(hk) : 2'(HK_REJECT);
  endfunction

endpackage

### hdl/nmea_gga_rmc_field_parser_top.sv
// Top level of the NMEA GGA/RMC field parser: input and output registers around the core.
//
// The input channel takes one received ASCII character per word (rx_byte_i with
// in_valid_i / in_stall_o). The output channel gives at most one word per input
// character (out_valid_o / out_stall_i): a field character of a selected GGA or
// RMC field, a sentence end on '*', or an overflow when a sentence runs past
// LINE_LEN stored characters. Characters outside the selected fields, commas,
// header bytes and bytes between sentences give no output word.
// A character accepted into the input register is parsed from that register, and
// its output word is captured in the output register when the parse stage steps.
// One character is accepted per cycle, sustained, for as long as the output
// side keeps up; the input register, the parse logic and the output register
// form two stages, so a waiting output word does not stop the next character
// from being taken in.
// When out_stall_i is high with a word waiting, the word holds and in_stall_o
// rises once the input register is also full.
// Reset clears the sentence state, the line counter and both valid flags; no
// sentence is open after reset until a '$' arrives.
module nmea_gga_rmc_field_parser_top #(
  parameter int unsigned LINE_LEN = 128,
  parameter int unsigned LINES    = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] event_kind_o,
  output logic [1:0] sentence_kind_o,
  output logic [2:0] field_id_o,
  output logic [3:0] char_index_o,
  output logic [7:0] char_value_o,
  output logic       batch_complete_o
);
  import ngrp_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  result_t    out_q;
  logic       step;
  logic       has_result;
  result_t    result;
  logic       accept;

  // The parse stage moves on when the output register is empty or being read.
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign accept     = in_valid_i && !in_stall_o;

  ngrp_core #(
    .LINE_LEN(LINE_LEN),
    .LINES   (LINES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .has_result_o(has_result),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= has_result;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_byte_q <= rx_byte_i;
    if (step && has_result) out_q <= result;
  end

  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = 2'(out_q.event_kind);
  assign sentence_kind_o  = out_q.sentence_kind;
  assign field_id_o       = out_q.field_id;
  assign char_index_o     = out_q.char_index;
  assign char_value_o     = out_q.char_value;
  assign batch_complete_o = out_q.batch_complete;

endmodule

### hdl/ngrp_core.sv
// Sentence state registers and the single-pass parse logic for one byte.
module ngrp_core #(
  parameter int unsigned LINE_LEN = 128,
  parameter int unsigned LINES    = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  output logic            has_result_o,
  output ngrp_pkg::result_t result_o
);
  import ngrp_pkg::*;

  localparam int unsigned LC_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam logic [7:0] LINE_LEN_C = 8'(LINE_LEN);

  logic            in_sent_q, in_sent_d;
  logic [7:0]      pos_q, pos_d;
  logic [3:0]      commas_q, commas_d;
  logic [3:0]      fcc_q, fcc_d;
  header_e         hk_q, hk_d;
  logic [LC_W-1:0] lc_q, lc_d;

  header_e    hk_new;
  field_sel_t sel;

  // Header check on the characters that follow the dollar sign.
  function automatic header_e match_header(logic [7:0] pos, logic [7:0] c, header_e hk);
    header_e r;
    r = hk;
    case (pos)
      8'd1: if (hk == HK_MATCH && c != CH_G) r = HK_REJECT;
      8'd2: if (hk == HK_MATCH && !(c inside {CH_P, CH_L, CH_S, CH_N})) r = HK_REJECT;
      8'd3: begin
        if (hk == HK_MATCH) begin
          r = (c == CH_G) ? HK_GGA : (c == CH_R) ? HK_RMC : HK_REJECT;
        end
      end
      8'd4: if ((hk == HK_GGA && c != CH_G) || (hk == HK_RMC && c != CH_M)) r = HK_REJECT;
      8'd5: if ((hk == HK_GGA && c != CH_A) || (hk == HK_RMC && c != CH_C)) r = HK_REJECT;
      default: if (hk == HK_MATCH) r = HK_REJECT;
    endcase
    return r;
  endfunction

  always_comb begin
    in_sent_d    = in_sent_q;
    pos_d        = pos_q;
    commas_d     = commas_q;
    fcc_d        = fcc_q;
    hk_d         = hk_q;
    lc_d         = lc_q;
    has_result_o = 1'b0;
    result_o     = '0;
    hk_new       = match_header(pos_q, byte_i, hk_q);
    sel          = select_field(hk_new, commas_q);

    if (byte_i == CH_DOLLAR) begin
      in_sent_d = 1'b1;
      pos_d     = 8'd1;
      commas_d  = '0;
      fcc_d     = '0;
      hk_d      = HK_MATCH;
    end else if (in_sent_q) begin
      if (byte_i == CH_STAR) begin
        has_result_o        = 1'b1;
        result_o.event_kind = EV_END;
        if (32'(lc_q) + 32'd1 >= 32'(LINES)) begin
          lc_d                    = '0;
          result_o.batch_complete = 1'b1;
        end else begin
          lc_d = lc_q + 1'b1;
        end
        if (hk_q == HK_MATCH) hk_d = HK_REJECT;
        result_o.sentence_kind = kind_of(hk_q);
        in_sent_d = 1'b0;
      end else if (pos_q >= LINE_LEN_C) begin
        // The sentence is too long to store: drop it and report.
        has_result_o           = 1'b1;
        result_o.event_kind    = EV_OVF;
        result_o.sentence_kind = kind_of(hk_q);
        if (hk_q == HK_MATCH) hk_d = HK_REJECT;
        in_sent_d = 1'b0;
      end else begin
        hk_d  = hk_new;
        pos_d = pos_q + 8'd1;
        if (byte_i == CH_COMMA) begin
          if (commas_q != 4'(CNT_MAX)) commas_d = commas_q + 4'd1;
          fcc_d = '0;
        end else if (sel.hit && fcc_q < sel.limit) begin
          has_result_o           = 1'b1;
          result_o.event_kind    = EV_CHAR;
          result_o.sentence_kind = kind_of(hk_new);
          result_o.field_id      = 3'(sel.fid);
          result_o.char_index    = fcc_q;
          result_o.char_value    = byte_i;
          fcc_d                  = fcc_q + 4'd1;
        end else if (fcc_q != 4'(CNT_MAX)) begin
          fcc_d = fcc_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q <= 1'b0;
      pos_q     <= '0;
      commas_q  <= '0;
      fcc_q     <= '0;
      hk_q      <= HK_REJECT;
      lc_q      <= '0;
    end else if (step_i) begin
      in_sent_q <= in_sent_d;
      pos_q     <= pos_d;
      commas_q  <= commas_d;
      fcc_q     <= fcc_d;
      hk_q      <= hk_d;
      lc_q      <= lc_d;
    end
  end

endmodule
